[rtl/i2a_pkg.sv]
package i2a_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);
    localparam int NDIG_W      = $clog2(VALUE_WIDTH) + 1;

    localparam logic [5:0] RADIX_MIN    = 6'd2;
    localparam logic [5:0] RADIX_MAX    = 6'd36;
    localparam logic [5:0] DECIMAL_BASE = 6'd10;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    typedef struct packed {
        logic load;
        logic go;
    } t_div_ctl;

    typedef struct packed {
        logic       done;
        logic [5:0] rem;
        logic       nonzero;
    } t_div_stat;

    function automatic logic [7:0] digit_char(input logic [5:0] d);
        logic [7:0] r;
        if (d < 6'd10) begin
            r = CHAR_ZERO + {2'b00, d};
        end else begin
            r = CHAR_A + {2'b00, d} - 8'd10;
        end
        return r;
    endfunction

endpackage

[rtl/i2a_div.sv]
module i2a_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  i2a_pkg::t_div_ctl                   i_ctl,
    input  logic [i2a_pkg::VALUE_WIDTH-1:0]     i_dividend,
    input  logic [5:0]                          i_radix,
    output i2a_pkg::t_div_stat                  o_stat
);
    import i2a_pkg::*;

    logic [VALUE_WIDTH-1:0] r_quo;
    logic [5:0]             r_rem;
    logic [5:0]             r_radix;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_run;
    logic                   r_done;
    logic                   r_nz;

    logic [6:0] trial;
    logic [6:0] diff;
    logic       ge;
    logic [5:0] n_rem;

    // One restoring step per cycle: the dividend shifts out at the top while
    // quotient bits shift in at the bottom of the same register.
    always_comb begin
        trial = {r_rem, r_quo[VALUE_WIDTH-1]};
        ge    = (trial >= {1'b0, r_radix});
        diff  = trial - {1'b0, r_radix};
        n_rem = ge ? diff[5:0] : trial[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.load || i_ctl.go) begin
                if (i_ctl.load) begin
                    r_quo   <= i_dividend;
                    r_radix <= i_radix;
                end
                r_rem <= '0;
                r_nz  <= 1'b0;
                r_cnt <= CNT_W'(VALUE_WIDTH - 1);
                r_run <= 1'b1;
            end else if (r_run) begin
                r_quo <= {r_quo[VALUE_WIDTH-2:0], ge};
                r_rem <= n_rem;
                r_nz  <= r_nz | ge;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.done    = r_done;
    assign o_stat.rem     = r_rem;
    assign o_stat.nonzero = r_nz;

endmodule

[rtl/int64_to_radix_ascii.sv]
// Each digit comes from the bit-serial divider in 64 shift steps plus a handoff, then
// every character is read back and emitted. A bad radix gives its result in the cycle
// after start. One conversion at a time; busy drops as the last character goes out.
// Reset: synchronous, active low; clears the control state. No result can be stalled.
module int64_to_radix_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_value,
    input  logic [5:0]  i_radix,
    output logic        o_strobe,
    output logic [7:0]  o_character,
    output logic        o_last,
    output logic        o_bad_radix
);
    import i2a_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_READ,
        S_EMIT
    } t_state;

    t_state r_state, n_state;

    logic [NDIG_W-1:0] r_ndig, n_ndig;
    logic              r_neg, n_neg;
    logic              r_strobe, n_strobe;
    logic [7:0]        r_char, n_char;
    logic              r_last, n_last;
    logic              r_bad, n_bad;

    logic [5:0] r_mem [VALUE_WIDTH];
    logic [5:0] r_rd_data;
    logic       mem_we;
    logic       mem_re;

    t_div_ctl              div_ctl;
    t_div_stat             div_stat;
    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   radix_bad;
    logic                   in_neg;
    logic [NDIG_W-1:0]      rd_idx;

    assign raw       = i_value[VALUE_WIDTH-1:0];
    assign radix_bad = (i_radix < RADIX_MIN) || (i_radix > RADIX_MAX);
    assign in_neg    = raw[VALUE_WIDTH-1] && (i_radix == DECIMAL_BASE);
    assign mag       = in_neg ? ('0 - raw) : raw;
    assign rd_idx    = r_ndig - 1'b1;

    i2a_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (mag),
        .i_radix    (i_radix),
        .o_stat     (div_stat)
    );

    always_comb begin
        n_state     = r_state;
        n_ndig      = r_ndig;
        n_neg       = r_neg;
        n_strobe    = 1'b0;
        n_char      = r_char;
        n_last      = r_last;
        n_bad       = r_bad;
        div_ctl     = '0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (radix_bad) begin
                        n_strobe = 1'b1;
                        n_char   = '0;
                        n_last   = 1'b1;
                        n_bad    = 1'b1;
                    end else begin
                        div_ctl.load = 1'b1;
                        n_neg        = in_neg;
                        n_ndig       = '0;
                        n_state      = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    mem_we = 1'b1;
                    n_ndig = r_ndig + 1'b1;
                    if (div_stat.nonzero) begin
                        div_ctl.go = 1'b1;
                    end else begin
                        n_state = r_neg ? S_SIGN : S_READ;
                    end
                end
            end
            S_SIGN: begin
                n_strobe = 1'b1;
                n_char   = CHAR_MINUS;
                n_last   = 1'b0;
                n_bad    = 1'b0;
                n_state  = S_READ;
            end
            S_READ: begin
                // Digits were stored least significant first; read them back in reverse.
                mem_re  = 1'b1;
                n_ndig  = rd_idx;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_strobe = 1'b1;
                n_char   = digit_char(r_rd_data);
                n_last   = (r_ndig == '0);
                n_bad    = 1'b0;
                n_state  = (r_ndig == '0) ? S_IDLE : S_READ;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
        r_ndig <= n_ndig;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
        r_bad  <= n_bad;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_ndig[CNT_W-1:0]] <= div_stat.rem;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[rd_idx[CNT_W-1:0]];
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_character = r_char;
    assign o_last      = r_last;
    assign o_bad_radix = r_bad;

endmodule
